FILE: rtl/assert_macros.svh
// assertion helper macros shared by the rtl files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/mlcr_pkg.sv
// shared constants for the midpoint line color rasterizer
// no dependencies
`timescale 1ns / 1ps

package mlcr_pkg;

	// field widths of the stream words
	localparam int COORD_FIELD_W = 12;
	localparam int COLOR_W       = 8;
	localparam int IN_TDATA_W    = 4 * COORD_FIELD_W + 6 * COLOR_W;
	localparam int OUT_TDATA_W   = 2 * COORD_FIELD_W + 3 * COLOR_W;

	// parameter defaults and limits
	localparam int COORD_BITS_DEF      = 12;
	localparam int COLOR_FRAC_BITS_DEF = 16;
	localparam int COORD_MAX_W         = 16;

	localparam int NUM_CH = 3;

	// word kind on the input tuser
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

endpackage

FILE: rtl/midpoint_line_color_raster_unit.sv
// midpoint line rasterizer with rgb interpolation, top level
// depends on mlcr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Input channel s_*: each word is a load (tuser = 0) or a step (tuser = 1).
// A load latches two endpoints and their colors and produces no output word.
// A step produces one pixel word on m_* with tlast set on the line's final
// pixel; a step with no line in progress produces nothing.
// After a load is taken, s_tready stays low while it is set up: a setup
// state, then a restoring divider shared by the three color channels, with a
// start state for each channel and then one quotient bit per cycle.
// The pixel word of a step is registered and shows on m_* in the cycle after
// the step is taken, so steps can stream at one per cycle while m_tready is high.
// s_tready is high only while no load is being set up and the output register
// is free or being emptied in the same cycle; a stalled receiver thus holds
// off the input after one pending pixel.
// Reset clears the line, the sequencer and the output valid; the first word
// after reset should be a load.
module midpoint_line_color_raster_unit #(
	parameter int COORD_BITS      = mlcr_pkg::COORD_BITS_DEF,
	parameter int COLOR_FRAC_BITS = mlcr_pkg::COLOR_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// start_x, start_y, end_x, end_y, start_red, start_green, start_blue,
	// end_red, end_green, end_blue
	input  logic [mlcr_pkg::IN_TDATA_W-1:0]   s_tdata,
	// mode
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue
	output logic [mlcr_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// last_pixel
	output logic                               m_tlast
);

	localparam int CW   = COORD_BITS;
	localparam int FW   = mlcr_pkg::COORD_FIELD_W;
	localparam int KW   = mlcr_pkg::COLOR_W;
	localparam int MW   = mlcr_pkg::COORD_MAX_W;
	localparam int NCH  = mlcr_pkg::NUM_CH;
	localparam int F    = COLOR_FRAC_BITS;
	localparam int DW   = COORD_BITS + 3;          // decision value
	localparam int IW   = KW + 1 + F;              // signed color accumulator
	localparam int QW   = KW + F;                  // divider quotient
	localparam int CNTW = $clog2(QW);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SETUP = 4'b0010,
		ST_DLOAD = 4'b0100,
		ST_DIV   = 4'b1000
	} state_t;

	function automatic logic [CW-1:0] to_coord(input logic [FW-1:0] v);
		logic [MW-1:0] w;
		w = MW'(v);
		return w[CW-1:0];
	endfunction

	function automatic logic [FW-1:0] to_field(input logic [CW-1:0] v);
		logic [MW-1:0] w;
		w = MW'(v);
		return w[FW-1:0];
	endfunction

	// round to nearest and clamp to 0..255
	function automatic logic [KW-1:0] color_out(input logic signed [IW-1:0] acc);
		logic [IW-1:0] sum;
		logic [KW:0]   v;
		sum = IW'(unsigned'(acc)) + IW'({1'b1, {(F-1){1'b0}}});
		v = sum[F+KW:F];
		if (acc[IW-1] || acc == '0) begin
			return '0;
		end else if (v[KW]) begin
			return {KW{1'b1}};
		end else begin
			return v[KW-1:0];
		end
	endfunction

	state_t state_q;

	logic in_acc;
	logic out_free;

	// raw load word
	logic [CW-1:0] ld_sx_q, ld_sy_q, ld_ex_q, ld_ey_q;
	logic [KW-1:0] col0_q [NCH];
	logic [KW-1:0] col1_q [NCH];

	// line state
	logic                 line_active_q;
	logic                 major_is_x_q;
	logic                 step_down_q;
	logic [CW-1:0]        cur_x_q, cur_y_q, major_end_q, maj_delta_q;
	logic signed [DW-1:0] d_q, dinc_pos_q, dinc_zero_q;
	logic signed [IW-1:0] acc_q [NCH];
	logic signed [IW-1:0] inc_q [NCH];

	// shared divider
	logic [1:0]      ch_q;
	logic [CNTW-1:0] cnt_q;
	logic [CW-1:0]   rem_q;
	logic [QW-1:0]   quo_q;
	logic            neg_q;

	// output register
	logic          m_tvalid_q;
	logic [FW-1:0] px_q, py_q;
	logic [KW-1:0] pr_q, pg_q, pb_q;
	logic          last_q;

	// setup datapath
	logic [CW-1:0] adx, ady, nsx, nsy, nex, ney;
	logic          mx, swap;
	logic [CW-1:0] maj_d, min_d, mend;
	logic          sdown;
	logic signed [DW-1:0] min2, d0, dpos;
	logic [KW-1:0] c0s [NCH];
	logic [KW-1:0] c1s [NCH];

	// divider datapath
	logic [CW:0]   shifted;
	logic [CW+1:0] diff;
	logic          ge;
	logic [QW-1:0] q_final;
	logic signed [IW-1:0] q_ext, inc_new;
	logic [KW-1:0] dc0, dc1;

	// step datapath
	logic [CW-1:0] maj_cur;
	logic          last_now;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign in_acc   = s_tvalid && s_tready;

	always_comb begin
		adx   = (ld_sx_q > ld_ex_q) ? ld_sx_q - ld_ex_q : ld_ex_q - ld_sx_q;
		ady   = (ld_sy_q > ld_ey_q) ? ld_sy_q - ld_ey_q : ld_ey_q - ld_sy_q;
		mx    = ady <= adx;
		swap  = mx ? (ld_ex_q < ld_sx_q) : (ld_ey_q < ld_sy_q);
		nsx   = swap ? ld_ex_q : ld_sx_q;
		nsy   = swap ? ld_ey_q : ld_sy_q;
		nex   = swap ? ld_sx_q : ld_ex_q;
		ney   = swap ? ld_sy_q : ld_ey_q;
		mend  = mx ? nex : ney;
		maj_d = mx ? adx : ady;
		min_d = mx ? ady : adx;
		sdown = mx ? (ney < nsy) : (nex < nsx);
		min2  = DW'({min_d, 1'b0});
		d0    = min2 - DW'(maj_d);
		dpos  = min2 - DW'({maj_d, 1'b0});
		for (int i = 0; i < NCH; i++) begin
			c0s[i] = swap ? col1_q[i] : col0_q[i];
			c1s[i] = swap ? col0_q[i] : col1_q[i];
		end
	end

	always_comb begin
		shifted = {rem_q, quo_q[QW-1]};
		diff    = {1'b0, shifted} - (CW+2)'(maj_delta_q);
		ge      = !diff[CW+1];
		q_final = {quo_q[QW-2:0], ge};
		q_ext   = IW'(q_final);
		if (maj_delta_q == '0) begin
			inc_new = '0;
		end else begin
			inc_new = neg_q ? -q_ext : q_ext;
		end
		dc0 = col0_q[ch_q];
		dc1 = col1_q[ch_q];
	end

	assign maj_cur  = major_is_x_q ? cur_x_q : cur_y_q;
	assign last_now = maj_cur >= major_end_q;

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			line_active_q <= 1'b0;
			m_tvalid_q    <= 1'b0;
			ch_q          <= '0;
			cnt_q         <= '0;
		end else begin
			if (in_acc && s_tuser == mlcr_pkg::MODE_STEP && line_active_q) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser == mlcr_pkg::MODE_LOAD) begin
							line_active_q <= 1'b0;
							state_q       <= ST_SETUP;
						end else if (line_active_q && last_now) begin
							line_active_q <= 1'b0;
						end
					end
				end
				ST_SETUP: begin
					ch_q    <= '0;
					state_q <= ST_DLOAD;
				end
				ST_DLOAD: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNTW'(QW - 1)) begin
						if (ch_q == 2'(NCH - 1)) begin
							line_active_q <= 1'b1;
							state_q       <= ST_IDLE;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= ST_DLOAD;
						end
					end else begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && s_tuser == mlcr_pkg::MODE_LOAD) begin
					ld_sx_q <= to_coord(s_tdata[11:0]);
					ld_sy_q <= to_coord(s_tdata[23:12]);
					ld_ex_q <= to_coord(s_tdata[35:24]);
					ld_ey_q <= to_coord(s_tdata[47:36]);
					for (int i = 0; i < NCH; i++) begin
						col0_q[i] <= s_tdata[48 + KW*i +: KW];
						col1_q[i] <= s_tdata[72 + KW*i +: KW];
					end
				end else if (in_acc && line_active_q) begin
					px_q   <= to_field(cur_x_q);
					py_q   <= to_field(cur_y_q);
					pr_q   <= color_out(acc_q[0]);
					pg_q   <= color_out(acc_q[1]);
					pb_q   <= color_out(acc_q[2]);
					last_q <= last_now;
					if (!last_now) begin
						// minor axis moves only on a strictly positive decision
						if (d_q > 0) begin
							if (major_is_x_q) begin
								cur_y_q <= step_down_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
							end else begin
								cur_x_q <= step_down_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
							end
							d_q <= d_q + dinc_pos_q;
						end else begin
							d_q <= d_q + dinc_zero_q;
						end
						if (major_is_x_q) begin
							cur_x_q <= cur_x_q + CW'(1);
						end else begin
							cur_y_q <= cur_y_q + CW'(1);
						end
						for (int i = 0; i < NCH; i++) begin
							acc_q[i] <= acc_q[i] + inc_q[i];
						end
					end
				end
			end
			ST_SETUP: begin
				major_is_x_q <= mx;
				step_down_q  <= sdown;
				cur_x_q      <= nsx;
				cur_y_q      <= nsy;
				major_end_q  <= mend;
				maj_delta_q  <= maj_d;
				d_q          <= d0;
				dinc_pos_q   <= dpos;
				dinc_zero_q  <= min2;
				for (int i = 0; i < NCH; i++) begin
					col0_q[i] <= c0s[i];
					col1_q[i] <= c1s[i];
					acc_q[i]  <= IW'({c0s[i], {F{1'b0}}});
				end
			end
			ST_DLOAD: begin
				rem_q <= '0;
				quo_q <= {((dc1 >= dc0) ? dc1 - dc0 : dc0 - dc1), {F{1'b0}}};
				neg_q <= dc1 < dc0;
			end
			ST_DIV: begin
				rem_q <= ge ? diff[CW-1:0] : shifted[CW-1:0];
				quo_q <= q_final;
				if (cnt_q == CNTW'(QW - 1)) begin
					inc_q[ch_q] <= inc_new;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {pb_q, pg_q, pr_q, py_q, px_q};
	assign m_tlast  = last_q;

	// a new pixel word only follows a taken step
	`ASSERT_CLK(a_word_after_step, clk, arst_n,
		(m_tvalid_q && !$past(m_tvalid_q)) |-> $past(in_acc && s_tuser == mlcr_pkg::MODE_STEP),
		"pixel word without a step")
	// a load drops any line in progress until its setup is done
	`ASSERT_CLK(a_load_clears_line, clk, arst_n,
		(in_acc && s_tuser == mlcr_pkg::MODE_LOAD) |=> !line_active_q,
		"line still active after load")
	// the major coordinate never passes the line end
	`ASSERT_NEVER(a_major_in_range, clk, arst_n,
		line_active_q && (maj_cur > major_end_q),
		"major coordinate beyond line end")
	// the final pixel ends the line
	`ASSERT_CLK(a_last_ends_line, clk, arst_n,
		(in_acc && s_tuser == mlcr_pkg::MODE_STEP && line_active_q && last_now) |=>
			(!line_active_q && m_tvalid_q && last_q),
		"line not ended after final pixel")

endmodule

FILE: sim/tb_top.sv
// self-checking bench for midpoint_line_color_raster_unit: directed table, then random lines
// depends on mlcr_pkg and the rasterizer rtl; predicts pixel words on its own or takes them from the directed table
`timescale 1ns / 1ps

module tb_top;

	localparam int FRAC        = mlcr_pkg::COLOR_FRAC_BITS_DEF;
	localparam int WORD_TARGET = 500;
	localparam int CALM_FROM   = 430;
	localparam int QUIET_LIMIT = 1000;
	localparam int DRAIN_WAIT  = 100;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic        last;
	} pixel_t;

	typedef enum {CHK_MODEL, CHK_NONE, CHK_PIXEL} chk_kind_t;

	typedef struct {
		logic                            mode;
		logic [mlcr_pkg::IN_TDATA_W-1:0] data;
		chk_kind_t                       chk;
		pixel_t                          pix;
	} row_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [mlcr_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                             s_tuser;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [mlcr_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             m_tlast;

	pixel_t pending_pixels[$];
	row_t   directed_rows[$];
	int     errors = 0;
	int     words_sent = 0;
	bit     calm = 0;

	// predicted line state
	bit          line_on;
	bit          major_x;
	bit          minor_down;
	logic [11:0] cur_x;
	logic [11:0] cur_y;
	logic [11:0] major_stop;
	int          decision;
	int          minor_len;
	int          major_len;
	longint      color_acc[mlcr_pkg::NUM_CH];
	longint      color_inc[mlcr_pkg::NUM_CH];

	midpoint_line_color_raster_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic int gap(input logic [11:0] a, input logic [11:0] b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	function automatic longint color_slope(input int c0, input int c1, input int len);
		longint q;
		if (len <= 0)
			return 0;
		q = (longint'((c1 >= c0) ? c1 - c0 : c0 - c1) << FRAC) / len;
		return (c1 >= c0) ? q : -q;
	endfunction

	function automatic logic [7:0] color_round(input longint a);
		longint v;
		if (a <= 0)
			return '0;
		v = (a + (longint'(1) << (FRAC - 1))) >>> FRAC;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	// advances the predicted line by one input word; returns 1 when a pixel comes out
	function automatic bit raster_word(input logic mode,
			input logic [mlcr_pkg::IN_TDATA_W-1:0] w, output pixel_t p);
		logic [11:0]     sx, sy, ex, ey, t;
		logic [2:0][7:0] c0, c1, ct;
		logic [11:0]     maj;
		bit              swap;
		p = '0;
		if (mode == mlcr_pkg::MODE_LOAD) begin
			sx = w[11:0];
			sy = w[23:12];
			ex = w[35:24];
			ey = w[47:36];
			for (int i = 0; i < mlcr_pkg::NUM_CH; i++) begin
				c0[i] = w[48 + 8 * i +: 8];
				c1[i] = w[72 + 8 * i +: 8];
			end
			major_x = gap(ey, sy) <= gap(ex, sx);
			swap = major_x ? (ex < sx) : (ey < sy);
			if (swap) begin
				t = sx; sx = ex; ex = t;
				t = sy; sy = ey; ey = t;
				ct = c0; c0 = c1; c1 = ct;
			end
			cur_x = sx;
			cur_y = sy;
			if (major_x) begin
				major_stop = ex;
				major_len = int'(ex) - int'(sx);
				minor_len = gap(ey, sy);
				minor_down = ey < sy;
			end else begin
				major_stop = ey;
				major_len = int'(ey) - int'(sy);
				minor_len = gap(ex, sx);
				minor_down = ex < sx;
			end
			decision = 2 * minor_len - major_len;
			for (int i = 0; i < mlcr_pkg::NUM_CH; i++) begin
				color_acc[i] = longint'(c0[i]) << FRAC;
				color_inc[i] = color_slope(c0[i], c1[i], major_len);
			end
			line_on = 1;
			return 0;
		end
		if (!line_on)
			return 0;
		maj = major_x ? cur_x : cur_y;
		p.x = cur_x;
		p.y = cur_y;
		p.r = color_round(color_acc[0]);
		p.g = color_round(color_acc[1]);
		p.b = color_round(color_acc[2]);
		p.last = maj >= major_stop;
		if (p.last) begin
			line_on = 0;
			return 1;
		end
		if (decision > 0) begin
			if (major_x)
				cur_y = minor_down ? cur_y - 12'd1 : cur_y + 12'd1;
			else
				cur_x = minor_down ? cur_x - 12'd1 : cur_x + 12'd1;
			decision += 2 * (minor_len - major_len);
		end else begin
			decision += 2 * minor_len;
		end
		if (major_x)
			cur_x = cur_x + 12'd1;
		else
			cur_y = cur_y + 12'd1;
		for (int i = 0; i < mlcr_pkg::NUM_CH; i++)
			color_acc[i] += color_inc[i];
		return 1;
	endfunction

	function automatic void add_load(input int sx, input int sy, input int ex, input int ey,
			input int sr, input int sg, input int sb, input int er, input int eg, input int eb);
		row_t row;
		row.mode = mlcr_pkg::MODE_LOAD;
		row.data = {8'(eb), 8'(eg), 8'(er), 8'(sb), 8'(sg), 8'(sr),
			12'(ey), 12'(ex), 12'(sy), 12'(sx)};
		row.chk = CHK_NONE;
		row.pix = '0;
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	function automatic void add_step(input chk_kind_t chk, input int x, input int y,
			input int r, input int g, input int b, input bit last);
		row_t row;
		row.mode = mlcr_pkg::MODE_STEP;
		row.data = '0;
		row.chk = chk;
		row.pix = {12'(x), 12'(y), 8'(r), 8'(g), 8'(b), last};
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	function automatic int pick_end(input int s, input int span);
		int e;
		e = ($urandom_range(0, 1) == 1) ? s + span : s - span;
		if (e < 0 || e > 4095)
			e = 2 * s - e;
		return e;
	endfunction

	task automatic send_word(input logic mode, input logic [mlcr_pkg::IN_TDATA_W-1:0] data);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic issue(input logic mode, input logic [mlcr_pkg::IN_TDATA_W-1:0] data);
		pixel_t p;
		calm = words_sent >= CALM_FROM;
		send_word(mode, data);
		if (raster_word(mode, data, p))
			pending_pixels.insert(pending_pixels.size(), p);
		words_sent++;
	endtask

	// receiver side: ready comes in random bursts, steady near the end
	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			m_tready <= calm || ($urandom_range(0, 2) != 0);
			repeat (calm ? 1 : $urandom_range(1, 12)) @(posedge clk);
		end
	end

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel word, expected none, got x=%0d y=%0d",
					$time, m_tdata[11:0], m_tdata[23:12]);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("pixel_x", want.x, m_tdata[11:0]);
				check_field("pixel_y", want.y, m_tdata[23:12]);
				check_field("pixel_red", want.r, m_tdata[31:24]);
				check_field("pixel_green", want.g, m_tdata[39:32]);
				check_field("pixel_blue", want.b, m_tdata[47:40]);
				check_field("last_pixel", want.last, m_tlast);
			end
		end
	end

	// watchdog on cycles where neither side moves a word
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		pixel_t              p;
		bit                  hit;
		bit                  paused;
		bit                  junk;
		int                  sx, sy, ex, ey, span, cap, n;
		logic [47:0]         colors;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = mlcr_pkg::MODE_LOAD;
		line_on = 0;
		major_x = 0;
		minor_down = 0;
		cur_x = '0;
		cur_y = '0;
		major_stop = '0;
		decision = 0;
		minor_len = 0;
		major_len = 0;
		for (int i = 0; i < mlcr_pkg::NUM_CH; i++) begin
			color_acc[i] = 0;
			color_inc[i] = 0;
		end
		paused = 0;

		// step with no line after reset
		add_step(CHK_NONE, 0, 0, 0, 0, 0, 0);
		// zero-length line, then a step once it has ended
		add_load(100, 200, 100, 200, 10, 20, 30, 200, 210, 220);
		add_step(CHK_PIXEL, 100, 200, 10, 20, 30, 1);
		add_step(CHK_NONE, 0, 0, 0, 0, 0, 0);
		// full diagonal, equal slopes go x-major
		add_load(0, 0, 4095, 4095, 0, 0, 0, 255, 255, 255);
		add_step(CHK_PIXEL, 0, 0, 0, 0, 0, 0);
		add_step(CHK_MODEL, 0, 0, 0, 0, 0, 0);
		add_step(CHK_MODEL, 0, 0, 0, 0, 0, 0);
		// new line mid-run, swapped endpoints, minor axis going down
		add_load(4095, 0, 0, 4095, 255, 0, 255, 0, 255, 0);
		add_step(CHK_PIXEL, 0, 4095, 0, 255, 0, 0);
		add_step(CHK_MODEL, 0, 0, 0, 0, 0, 0);
		add_step(CHK_MODEL, 0, 0, 0, 0, 0, 0);
		// decision starts at zero so the minor coordinate holds first
		add_load(0, 0, 2, 1, 0, 128, 255, 255, 0, 1);
		add_step(CHK_PIXEL, 0, 0, 0, 128, 255, 0);
		add_step(CHK_PIXEL, 1, 0, 128, 64, 128, 0);
		add_step(CHK_PIXEL, 2, 1, 255, 0, 1, 1);
		// y-major with x going down
		add_load(10, 0, 3, 20, 50, 60, 70, 70, 40, 250);
		add_step(CHK_MODEL, 0, 0, 0, 0, 0, 0);
		add_step(CHK_MODEL, 0, 0, 0, 0, 0, 0);
		add_step(CHK_MODEL, 0, 0, 0, 0, 0, 0);
		// vertical at the far corner, swapped
		add_load(4095, 4095, 4095, 4093, 255, 255, 255, 0, 0, 0);
		add_step(CHK_PIXEL, 4095, 4093, 0, 0, 0, 0);
		add_step(CHK_MODEL, 0, 0, 0, 0, 0, 0);
		add_step(CHK_PIXEL, 4095, 4095, 255, 255, 255, 1);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			send_word(directed_rows[k].mode, directed_rows[k].data);
			hit = raster_word(directed_rows[k].mode, directed_rows[k].data, p);
			if (directed_rows[k].chk == CHK_MODEL && hit)
				pending_pixels.insert(pending_pixels.size(), p);
			else if (directed_rows[k].chk == CHK_PIXEL)
				pending_pixels.insert(pending_pixels.size(), directed_rows[k].pix);
		end

		while (words_sent < WORD_TARGET) begin
			if (!paused && words_sent >= WORD_TARGET / 2) begin
				// hold the input until every pixel so far has drained
				paused = 1;
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_pixels.size() != 0) @(posedge clk);
			end
			span = ($urandom_range(0, 9) == 0) ? 200 : 12;
			junk = $urandom_range(0, 19) == 0;
			sx = $urandom_range(0, 4095);
			sy = $urandom_range(0, 4095);
			if (junk) begin
				ex = $urandom_range(0, 4095);
				ey = $urandom_range(0, 4095);
			end else begin
				ex = pick_end(sx, $urandom_range(0, span));
				ey = pick_end(sy, $urandom_range(0, span));
			end
			colors = {16'($urandom()), $urandom()};
			issue(mlcr_pkg::MODE_LOAD, {colors, 12'(ey), 12'(ex), 12'(sy), 12'(sx)});
			if (junk)
				cap = $urandom_range(0, 3);
			else if ($urandom_range(0, 9) == 0)
				cap = $urandom_range(0, span);
			else
				cap = 5000;
			n = 0;
			while (line_on && n < cap && words_sent < WORD_TARGET) begin
				issue(mlcr_pkg::MODE_STEP, {$urandom(), $urandom(), $urandom()});
				n++;
			end
			if ($urandom_range(0, 9) == 0 && words_sent < WORD_TARGET)
				issue(mlcr_pkg::MODE_STEP, {$urandom(), $urandom(), $urandom()});
		end
		s_tvalid <= 1'b0;

		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/mlcr_pkg.sv
rtl/midpoint_line_color_raster_unit.sv
sim/tb_top.sv
